### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-qualified property checks for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define GCIC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent
`define GCIC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/gcic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcic_pkg
// Fixed-point constants and CORDIC arctangent table for the course unit.
// ----------------------------------------------------------------------------
package gcic_pkg;

  // Internal angle and trig format: signed Q30
  localparam int QB     = 30;
  localparam int ITER   = 30;
  localparam int TRIG_W = 32;

  localparam logic signed [35:0] PI_Q      = 36'sd3373259426;
  localparam logic signed [35:0] TWO_PI_Q  = 36'sd6746518852;
  localparam logic signed [35:0] HALF_PI_Q = 36'sd1686629713;
  localparam logic signed [35:0] GAIN_Q    = 36'sd652032874;

  // atan(2^-i) in Q30; from i = 10 on the value is an exact power of two
  function automatic logic [31:0] atan_q(input logic [4:0] idx);
    logic [31:0] res;
    case (idx)
      5'd0:    res = 32'd843314857;
      5'd1:    res = 32'd497837829;
      5'd2:    res = 32'd263043837;
      5'd3:    res = 32'd133525159;
      5'd4:    res = 32'd67021687;
      5'd5:    res = 32'd33543516;
      5'd6:    res = 32'd16775851;
      5'd7:    res = 32'd8388437;
      5'd8:    res = 32'd4194283;
      5'd9:    res = 32'd2097149;
      default: res = 32'd1 << (5'd30 - idx);
    endcase
    return res;
  endfunction

endpackage

### hw/rtl/gcic_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcic_in_if
// Input channel: start and end point of one course request.
// ----------------------------------------------------------------------------
interface gcic_in_if;
  logic                valid;
  logic                ready;
  logic signed [17:0]  start_lat;
  logic signed [18:0]  start_lon;
  logic signed [17:0]  end_lat;
  logic signed [18:0]  end_lon;

  modport source (output valid, start_lat, start_lon, end_lat, end_lon, input ready);
  modport sink   (input valid, start_lat, start_lon, end_lat, end_lon, output ready);
endinterface

### hw/rtl/gcic_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcic_out_if
// Output channel: initial true course and pole flag.
// ----------------------------------------------------------------------------
interface gcic_out_if;
  logic        valid;
  logic        ready;
  logic [18:0] true_course;
  logic        at_pole;

  modport source (output valid, true_course, at_pole, input ready);
  modport sink   (input valid, true_course, at_pole, output ready);
endinterface

### hw/rtl/gcic_sincos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcic_sincos
// Pipelined sine/cosine: range reduction mod 2pi, quadrant fold, then one
// rotation-mode CORDIC step per stage.
// ----------------------------------------------------------------------------
module gcic_sincos #(
  parameter int IN_W      = 34,
  parameter int RED_STEPS = 2
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [IN_W-1:0]              angle_i,
  output logic signed [gcic_pkg::TRIG_W-1:0]  sin_o,
  output logic signed [gcic_pkg::TRIG_W-1:0]  cos_o
);

  localparam int MW = (IN_W > 34) ? IN_W : 34;
  localparam int CW = 34;
  localparam int N  = gcic_pkg::ITER;

  localparam logic [MW-1:0]        TWO_PI_M = MW'(gcic_pkg::TWO_PI_Q);
  localparam logic signed [MW:0]   PI_R     = (MW+1)'(gcic_pkg::PI_Q);
  localparam logic signed [MW:0]   TWO_PI_R = (MW+1)'(gcic_pkg::TWO_PI_Q);
  localparam logic signed [CW-1:0] PI_C     = CW'(gcic_pkg::PI_Q);
  localparam logic signed [CW-1:0] HALF_C   = CW'(gcic_pkg::HALF_PI_Q);
  localparam logic signed [CW-1:0] GAIN_C   = CW'(gcic_pkg::GAIN_Q);

  logic [MW-1:0]        mag_q [RED_STEPS+1];
  logic                 sgn_q [RED_STEPS+1];
  logic signed [MW:0]   rem;
  logic signed [MW:0]   radj_d;
  logic signed [CW-1:0] radj_q;
  logic signed [CW-1:0] x_q [N+1];
  logic signed [CW-1:0] y_q [N+1];
  logic signed [CW-1:0] z_q [N+1];
  logic                 neg_q [N+1];

  // Take the magnitude for the truncating remainder
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q[0] <= angle_i[IN_W-1] ? MW'($unsigned(-angle_i)) : MW'($unsigned(angle_i));
      sgn_q[0] <= angle_i[IN_W-1];
    end
  end

  // Subtract 2pi multiples, one quotient bit per stage
  for (genvar j = 0; j < RED_STEPS; j++) begin : g_red
    localparam logic [MW-1:0] STEP_M = TWO_PI_M << (RED_STEPS - 1 - j);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mag_q[j+1] <= (mag_q[j] >= STEP_M) ? mag_q[j] - STEP_M : mag_q[j];
        sgn_q[j+1] <= sgn_q[j];
      end
    end
  end

  // Restore the sign and bring the remainder into [-pi, pi]
  always_comb begin
    rem = sgn_q[RED_STEPS] ? -$signed({1'b0, mag_q[RED_STEPS]})
                           : $signed({1'b0, mag_q[RED_STEPS]});
    if (rem > PI_R) begin
      radj_d = rem - TWO_PI_R;
    end else if (rem < -PI_R) begin
      radj_d = rem + TWO_PI_R;
    end else begin
      radj_d = rem;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      radj_q <= CW'(radj_d);
    end
  end

  // Fold into [-pi/2, pi/2] and seed the rotator
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= GAIN_C;
      y_q[0] <= '0;
      if (radj_q > HALF_C) begin
        z_q[0]   <= radj_q - PI_C;
        neg_q[0] <= 1'b1;
      end else if (radj_q < -HALF_C) begin
        z_q[0]   <= radj_q + PI_C;
        neg_q[0] <= 1'b1;
      end else begin
        z_q[0]   <= radj_q;
        neg_q[0] <= 1'b0;
      end
    end
  end

  // Rotation steps
  for (genvar i = 0; i < N; i++) begin : g_rot
    localparam logic signed [CW-1:0] AT = $signed(CW'(gcic_pkg::atan_q(5'(i))));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[i+1] <= neg_q[i];
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - AT;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + AT;
        end
      end
    end
  end

  // Undo the fold
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_o <= gcic_pkg::TRIG_W'(neg_q[N] ? -y_q[N] : y_q[N]);
      cos_o <= gcic_pkg::TRIG_W'(neg_q[N] ? -x_q[N] : x_q[N]);
    end
  end

endmodule

### hw/rtl/great_circle_initial_course.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// great_circle_initial_course
// Initial true course between two points on a sphere, fully pipelined.
// ----------------------------------------------------------------------------
// One item per clock while no result waits at the output. Three CORDIC
// sine/cosine pipelines run side by side, four multiply stages form the
// course arguments, and a 30-step vectoring CORDIC gives the angle. The
// whole pipeline holds when a result waits at the output, so a stall drops
// and repeats nothing. A start point whose cosine of latitude is below the
// threshold written through cfg_wdata_i is reported as a pole.
module great_circle_initial_course #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [16:0]       cfg_wdata_i,
  gcic_in_if.sink           in_i,
  gcic_out_if.source        out_o
);

  `include "assert_macros.svh"

  localparam int SHIFT  = gcic_pkg::QB - FRAC_BITS;
  localparam int AW     = 20 + SHIFT;
  localparam int RED    = (AW > 33) ? AW - 32 : 1;
  localparam int N      = gcic_pkg::ITER;
  localparam int TW     = gcic_pkg::TRIG_W;
  localparam int P      = RED + N + 4;
  localparam int NS     = P + 7 + N;
  localparam int CMP_W  = (18 + SHIFT > 32) ? 18 + SHIFT : 32;
  localparam int VW     = 36;
  localparam int ZW     = 35;

  localparam logic signed [63:0] HALF_LSB   = 64'sd1 <<< (SHIFT - 1);
  localparam logic signed [63:0] PI_OUT     = (64'(gcic_pkg::PI_Q) + HALF_LSB) >>> SHIFT;
  localparam logic signed [63:0] TWO_PI_OUT = (64'(gcic_pkg::TWO_PI_Q) + HALF_LSB) >>> SHIFT;
  localparam logic [18:0]        PI_OUT_F   = PI_OUT[18:0];
  localparam logic [18:0]        TWO_PI_F   = TWO_PI_OUT[18:0];
  localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(gcic_pkg::HALF_PI_Q);

  // Round a Q60 product to Q30, half up
  function automatic logic signed [TW-1:0] round_q(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd536870912;
    return t[61:30];
  endfunction

  logic                  adv;
  logic [NS-1:0]         vld_q;
  logic [16:0]           thr_q;

  logic signed [17:0]    lat1_q, lat2_q;
  logic signed [19:0]    dl_q;
  logic                  nd_q [P+1];

  logic signed [TW-1:0]  s1, c1, s2, c2, sdl, cdl;

  logic signed [63:0]    py_q, pa_q, pb_q, pc_q;
  logic signed [TW-1:0]  cdl1_q, cdl2_q, y2_q, a2_q, b2_q, y3_q, a3_q, y4_q;
  logic signed [32:0]    x4_q;
  logic                  pole1_q, pole2_q, pole3_q, pole4_q;
  logic                  north1_q, north2_q, north3_q, north4_q;

  logic signed [VW-1:0]  xe, ye;
  logic signed [VW-1:0]  vx_q [N+1];
  logic signed [VW-1:0]  vy_q [N+1];
  logic signed [ZW-1:0]  vz_q [N+1];
  logic                  vpole_q [N+1];
  logic                  vnorth_q [N+1];
  logic                  vzero_q [N+1];

  logic signed [ZW-1:0]  zr, course_full;
  logic [18:0]           course_q;
  logic                  at_pole_q;

  // Advance the whole pipeline unless a result is held at the output
  assign adv          = !vld_q[NS-1] || out_o.ready;
  assign in_i.ready   = adv;
  assign out_o.valid  = vld_q[NS-1];
  assign out_o.true_course = course_q;
  assign out_o.at_pole     = at_pole_q;

  // Threshold register and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 17'd1;
      vld_q <= '0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (adv) begin
        vld_q <= {vld_q[NS-2:0], in_i.valid};
      end
    end
  end

  // Capture the item and form the longitude difference
  always_ff @(posedge clk_i) begin
    if (adv) begin
      lat1_q  <= in_i.start_lat;
      lat2_q  <= in_i.end_lat;
      dl_q    <= 20'(in_i.end_lon) - 20'(in_i.start_lon);
      nd_q[0] <= (in_i.start_lat > 18'sd0);
    end
  end

  // Carry the hemisphere flag alongside the trig pipelines
  for (genvar k = 0; k < P; k++) begin : g_nd
    always_ff @(posedge clk_i) begin
      if (adv) begin
        nd_q[k+1] <= nd_q[k];
      end
    end
  end

  gcic_sincos #(.IN_W(AW), .RED_STEPS(RED)) u_sc_lat1 (
    .clk_i, .en_i(adv), .angle_i(AW'(lat1_q) <<< SHIFT), .sin_o(s1), .cos_o(c1)
  );
  gcic_sincos #(.IN_W(AW), .RED_STEPS(RED)) u_sc_lat2 (
    .clk_i, .en_i(adv), .angle_i(AW'(lat2_q) <<< SHIFT), .sin_o(s2), .cos_o(c2)
  );
  gcic_sincos #(.IN_W(AW), .RED_STEPS(RED)) u_sc_dlon (
    .clk_i, .en_i(adv), .angle_i(AW'(dl_q) <<< SHIFT), .sin_o(sdl), .cos_o(cdl)
  );

  // Multiply the trig terms and test for a pole start
  always_ff @(posedge clk_i) begin
    if (adv) begin
      py_q     <= 64'(sdl) * 64'(c2);
      pa_q     <= 64'(c1) * 64'(s2);
      pb_q     <= 64'(s1) * 64'(c2);
      cdl1_q   <= cdl;
      pole1_q  <= $signed(CMP_W'(c1)) < $signed(CMP_W'({thr_q, {SHIFT{1'b0}}}));
      north1_q <= nd_q[P];
    end
  end

  // Round the products
  always_ff @(posedge clk_i) begin
    if (adv) begin
      y2_q     <= round_q(py_q);
      a2_q     <= round_q(pa_q);
      b2_q     <= round_q(pb_q);
      cdl2_q   <= cdl1_q;
      pole2_q  <= pole1_q;
      north2_q <= north1_q;
    end
  end

  // Second product of the x term
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pc_q     <= 64'(b2_q) * 64'(cdl2_q);
      y3_q     <= y2_q;
      a3_q     <= a2_q;
      pole3_q  <= pole2_q;
      north3_q <= north2_q;
    end
  end

  // Finish the x term
  always_ff @(posedge clk_i) begin
    if (adv) begin
      x4_q     <= 33'(a3_q) - 33'(round_q(pc_q));
      y4_q     <= y3_q;
      pole4_q  <= pole3_q;
      north4_q <= north3_q;
    end
  end

  // Pre-rotate by a quarter turn so that x is not negative
  assign xe = VW'(x4_q);
  assign ye = VW'(y4_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vpole_q[0]  <= pole4_q;
      vnorth_q[0] <= north4_q;
      vzero_q[0]  <= (x4_q == '0) && (y4_q == '0);
      if (xe < 0) begin
        if (ye >= 0) begin
          vx_q[0] <= ye;
          vy_q[0] <= -xe;
          vz_q[0] <= HALF_PI_Z;
        end else begin
          vx_q[0] <= -ye;
          vy_q[0] <= xe;
          vz_q[0] <= -HALF_PI_Z;
        end
      end else begin
        vx_q[0] <= xe;
        vy_q[0] <= ye;
        vz_q[0] <= '0;
      end
    end
  end

  // Vectoring steps
  for (genvar i = 0; i < N; i++) begin : g_vec
    localparam logic signed [ZW-1:0] AT = $signed(ZW'(gcic_pkg::atan_q(5'(i))));
    always_ff @(posedge clk_i) begin
      if (adv) begin
        vpole_q[i+1]  <= vpole_q[i];
        vnorth_q[i+1] <= vnorth_q[i];
        vzero_q[i+1]  <= vzero_q[i];
        if (vy_q[i] > 0) begin
          vx_q[i+1] <= vx_q[i] + (vy_q[i] >>> i);
          vy_q[i+1] <= vy_q[i] - (vx_q[i] >>> i);
          vz_q[i+1] <= vz_q[i] + AT;
        end else begin
          vx_q[i+1] <= vx_q[i] - (vy_q[i] >>> i);
          vy_q[i+1] <= vy_q[i] + (vx_q[i] >>> i);
          vz_q[i+1] <= vz_q[i] - AT;
        end
      end
    end
  end

  // Round to the output scale and wrap into 0 to 2pi
  always_comb begin
    zr = (vz_q[N] + ZW'(HALF_LSB)) >>> SHIFT;
    if (vpole_q[N]) begin
      course_full = vnorth_q[N] ? ZW'(PI_OUT) : ZW'(TWO_PI_OUT);
    end else if (vzero_q[N]) begin
      course_full = '0;
    end else if (zr < 0) begin
      course_full = zr + ZW'(TWO_PI_OUT);
    end else begin
      course_full = zr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      course_q  <= course_full[18:0];
      at_pole_q <= vpole_q[N];
    end
  end

  `GCIC_ASSERT_IMP(a_pole_course, out_o.valid && out_o.at_pole, out_o.true_course == PI_OUT_F || out_o.true_course == TWO_PI_F, "pole item without pole course")
  `GCIC_ASSERT_NXT(a_stall_hold, !adv, vld_q == $past(vld_q), "pipeline moved while stalled")
  `GCIC_ASSERT_NXT(a_advance_shift, adv, vld_q[NS-1:1] == $past(vld_q[NS-2:0]), "valid bits lost or repeated")

endmodule

### tb/tb_great_circle_initial_course.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_great_circle_initial_course
// Drives start/end point pairs into the course unit with random gaps and
// output stalls. Predicts each course and pole flag in Q30 fixed point
// (CORDIC sine/cosine and vectoring arctangent), then compares every result
// in order. Covers field extremes, pole detection, all threshold extremes
// and a long output hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module tb_great_circle_initial_course;

  localparam int      FRAC    = 16;
  localparam int      Q_BITS  = 30;
  localparam int      STEPS   = 30;
  localparam int      LAT_MAX = 102944;
  localparam int      LON_MAX = 205888;
  localparam longint  PI_QV   = 64'sd3373259426;
  localparam longint  TWO_PIV = 64'sd6746518852;
  localparam longint  HALF_PI = 64'sd1686629713;
  localparam longint  K_GAIN  = 64'sd652032874;

  typedef struct packed {
    logic [18:0] course;
    logic        pole;
  } course_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [16:0] cfg_wdata_i;

  gcic_in_if  in_if ();
  gcic_out_if out_if ();

  great_circle_initial_course #(.FRAC_BITS(FRAC)) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  longint      atan_lut [STEPS];
  logic [16:0] threshold;
  course_t     pending_courses [$];
  int          mismatches;
  bit          gaps_on;
  bit          stalls_on;
  bit          hold_req;
  int          hold_left;

  // Clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Predictor ---------------------------------------------------------------

  function automatic longint atan_entry(input int i);
    longint unsigned acc;
    longint unsigned term;
    int k;
    acc = 0;
    if (i == 0) begin
      return 64'sd843314857;
    end
    for (k = 0; i * (2 * k + 1) <= 62; k++) begin
      term = (64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1);
      if (k % 2 == 1) begin
        acc -= term;
      end else begin
        acc += term;
      end
    end
    return longint'((acc + (64'd1 << 31)) >> 32);
  endfunction

  function automatic longint mul_q(input longint a, input longint b);
    return (a * b + (64'sd1 << (Q_BITS - 1))) >>> Q_BITS;
  endfunction

  function automatic longint round_out(input longint v);
    return (v + (64'sd1 << (Q_BITS - FRAC - 1))) >>> (Q_BITS - FRAC);
  endfunction

  function automatic void sin_cos(input longint ang, output longint s, output longint c);
    longint r, x, y, dx, dy;
    bit neg;
    r   = ang % TWO_PIV;
    x   = K_GAIN;
    y   = 0;
    neg = 1'b0;
    if (r > PI_QV) r -= TWO_PIV;
    if (r < -PI_QV) r += TWO_PIV;
    // fold into the right half plane
    if (r > HALF_PI) begin
      r -= PI_QV;
      neg = 1'b1;
    end else if (r < -HALF_PI) begin
      r += PI_QV;
      neg = 1'b1;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (r >= 0) begin
        x -= dx; y += dy; r -= atan_lut[i];
      end else begin
        x += dx; y -= dy; r += atan_lut[i];
      end
    end
    s = neg ? -y : y;
    c = neg ? -x : x;
  endfunction

  function automatic longint arc_tan2(input longint yi, input longint xi);
    longint x, y, z, t, dx, dy;
    x = xi;
    y = yi;
    z = 0;
    if (x == 0 && y == 0) begin
      return 0;
    end
    // quarter turn so that x is not negative
    if (x < 0) begin
      if (y >= 0) begin
        t = y; y = -x; x = t; z = HALF_PI;
      end else begin
        t = -y; y = x; x = t; z = -HALF_PI;
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += atan_lut[i];
      end else begin
        x -= dx; y += dy; z -= atan_lut[i];
      end
    end
    return z;
  endfunction

  function automatic course_t predict_course(input logic signed [17:0] lat1,
                                             input logic signed [18:0] lon1,
                                             input logic signed [17:0] lat2,
                                             input logic signed [18:0] lon2);
    longint  scale, s1, c1, s2, c2, sd, cd, y, x, crs;
    course_t res;
    scale = 64'sd1 << (Q_BITS - FRAC);
    sin_cos(longint'(lat1) * scale, s1, c1);
    if (c1 < longint'(threshold) * scale) begin
      crs = round_out(lat1 > 0 ? PI_QV : TWO_PIV);
      res.course = crs[18:0];
      res.pole   = 1'b1;
      return res;
    end
    sin_cos(longint'(lat2) * scale, s2, c2);
    sin_cos((longint'(lon2) - longint'(lon1)) * scale, sd, cd);
    y   = mul_q(sd, c2);
    x   = mul_q(c1, s2) - mul_q(mul_q(s1, c2), cd);
    crs = round_out(arc_tan2(y, x));
    if (crs < 0) crs += round_out(TWO_PIV);
    res.course = crs[18:0];
    res.pole   = 1'b0;
    return res;
  endfunction

  // Checking ----------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint want, input longint got);
    $display("%0t: mismatch %s: expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  // Predict on input item, compare on output item
  always @(posedge clk_i) begin
    course_t want;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        pending_courses.push_back(predict_course(in_if.start_lat, in_if.start_lon,
                                                 in_if.end_lat, in_if.end_lon));
      end
      if (out_if.valid && out_if.ready) begin
        if (pending_courses.size() == 0) begin
          report_mismatch("unexpected item", 0, out_if.true_course);
        end else begin
          want = pending_courses.pop_front();
          if (out_if.true_course !== want.course)
            report_mismatch("true_course", want.course, out_if.true_course);
          if (out_if.at_pole !== want.pole)
            report_mismatch("at_pole", want.pole, out_if.at_pole);
        end
      end
    end
  end

  // Receiver: random stalls and a counted hold-off
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else if (stalls_on) begin
      out_if.ready <= ($urandom_range(99) >= 26);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Stimulus ----------------------------------------------------------------

  // Offer one item, starting at a falling edge; return at the falling edge
  // after acceptance with valid still high
  task automatic send_points(input logic signed [17:0] lat1, input logic signed [18:0] lon1,
                             input logic signed [17:0] lat2, input logic signed [18:0] lon2);
    while (gaps_on && $urandom_range(99) < 26) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     = 1'b1;
    in_if.start_lat = lat1;
    in_if.start_lon = lon1;
    in_if.end_lat   = lat2;
    in_if.end_lon   = lon2;
    forever begin
      @(posedge clk_i);
      if (in_if.ready) break;
    end
    @(negedge clk_i);
  endtask

  task automatic send_random(input bit noise);
    if (noise) begin
      send_points(18'($urandom), 19'($urandom), 18'($urandom), 19'($urandom));
    end else begin
      send_points(18'($urandom_range(2 * LAT_MAX) - LAT_MAX),
                  19'($urandom_range(2 * LON_MAX) - LON_MAX),
                  18'($urandom_range(2 * LAT_MAX) - LAT_MAX),
                  19'($urandom_range(2 * LON_MAX) - LON_MAX));
    end
  endtask

  // Drop valid and let the pipeline empty before touching the register
  task automatic drain;
    in_if.valid = 1'b0;
    while (pending_courses.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_threshold(input logic [16:0] value);
    drain();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    threshold   = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  task automatic test_directed;
    send_points(0, 0, 0, 0);
    send_points(LAT_MAX, 0, 0, 0);
    send_points(-LAT_MAX, 0, 0, 0);
    send_points(0, 0, LAT_MAX, 0);
    send_points(0, 0, -LAT_MAX, 0);
    send_points(0, -LON_MAX, 0, LON_MAX);
    send_points(0, LON_MAX, 0, -LON_MAX);
    send_points(0, 0, 0, 10000);
    send_points(0, 0, 0, -10000);
    send_points(30000, 40000, 30000, 40000);
    send_points(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
    send_points(102943, 5, -3000, 7000);
    send_points(-131072, -262144, 131071, 262143);
    send_points(131071, 262143, -131072, -262144);
    send_points(-1, 1, 1, -1);
    send_points(50000, 100, -50000, 100);
  endtask

  // Poles, including a zero latitude start with a threshold of one
  task automatic test_pole_threshold;
    write_threshold(17'd65536);
    send_points(0, 0, 1000, 1000);
    send_points(20000, 0, 1000, 1000);
    send_points(-20000, 0, 1000, 1000);
    write_threshold(17'd131071);
    send_points(0, 0, 1000, 1000);
    send_points(LAT_MAX, 0, 0, 0);
    write_threshold(17'd0);
    send_points(LAT_MAX, 0, 0, 0);
    send_points(-LAT_MAX, 0, 0, 0);
    send_points(131071, 0, 0, 0);
    for (int n = 0; n < 40; n++) send_random($urandom_range(9) == 0);
  endtask

  task automatic test_random_thresholds;
    logic [16:0] settings [5] = '{17'd1, 17'd16384, 17'd60000, 17'd65536, 17'd400};
    foreach (settings[p]) begin
      write_threshold(settings[p]);
      for (int n = 0; n < 160; n++) send_random($urandom_range(9) == 0);
    end
  endtask

  // Long run with neither gaps nor stalls
  task automatic test_streaming;
    write_threshold(17'd200);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    for (int n = 0; n < 150; n++) send_random($urandom_range(9) == 0);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // Hold the output off while items keep coming, so the input stalls
  task automatic test_backpressure;
    gaps_on = 1'b0;
    @(posedge clk_i);
    hold_req = 1'b1;
    @(negedge clk_i);
    for (int n = 0; n < 150; n++) send_random(1'b0);
    gaps_on = 1'b1;
  endtask

  initial begin
    foreach (atan_lut[i]) atan_lut[i] = atan_entry(i);
    mismatches      = 0;
    threshold       = 17'd1;
    gaps_on         = 1'b1;
    stalls_on       = 1'b1;
    hold_req        = 1'b0;
    hold_left       = 0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    in_if.valid     = 1'b0;
    in_if.start_lat = '0;
    in_if.start_lon = '0;
    in_if.end_lat   = '0;
    in_if.end_lon   = '0;
    out_if.ready    = 1'b0;
    rst_ni          = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_pole_threshold();
    test_random_thresholds();
    test_streaming();
    test_backpressure();

    drain();
    repeat (100) @(negedge clk_i);
    if (mismatches == 0 && pending_courses.size() == 0) begin
      $display("tb_great_circle_initial_course: PASS");
    end else begin
      $display("tb_great_circle_initial_course: FAIL");
    end
    $finish;
  end

  // Run limit
  initial begin
    #10ms;
    $display("tb_great_circle_initial_course: FAIL");
    $finish;
  end

endmodule
